// ===== rtl/cbel_pkg.sv =====
// shared types, field widths and codes for the class bucketed event list
`default_nettype none

package cbel_pkg;

   localparam int unsigned CMD_W      = 2;
   localparam int unsigned CLASS_ID_W = 7;
   localparam int unsigned SITE_W     = 16;
   localparam int unsigned INDEX_W    = 10;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned COUNT_W    = 11;

   localparam int unsigned NUM_CLASSES_DEF     = 128;
   localparam int unsigned SLOTS_PER_CLASS_DEF = 1024;
   localparam int unsigned SITE_BITS_DEF       = 16;

   localparam logic [CMD_W-1:0] OP_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] OP_ERASE  = 2'd1;
   localparam logic [CMD_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

   typedef struct packed {
      logic load;
      logic clr_wr;
      logic decide;
      logic read_capture;
      logic scan_step;
      logic scan_end;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic             clr_last;
      logic             in_range;
      logic [CMD_W-1:0] op;
      logic             idx_ok;
      logic             scan_done;
      logic             out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== rtl/cbel_ctrl.sv =====
// controller state machine sequencing clear, insert, read and erase scans
`default_nettype none

module cbel_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire cbel_pkg::dp_sts_type sts,
   output cbel_pkg::dp_cmd_type     cmd
);
   import cbel_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_DECIDE = 6'b000100,
      S_RDWAIT = 6'b001000,
      S_SCAN   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_FINISH;
            if (sts.in_range) begin
               if (sts.op == OP_READ && sts.idx_ok) begin
                  state_in = S_RDWAIT;
               end else if (sts.op == OP_ERASE) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_RDWAIT: begin
            cmd.read_capture = 1'b1;
            state_in         = S_FINISH;
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               cmd.scan_end = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cbel_datapath.sv =====
// pair and count memories, scan pipeline, result and output registers
`default_nettype none

module cbel_datapath #(
   parameter int unsigned NUM_CLASSES     = cbel_pkg::NUM_CLASSES_DEF,
   parameter int unsigned SLOTS_PER_CLASS = cbel_pkg::SLOTS_PER_CLASS_DEF,
   parameter int unsigned SITE_BITS       = cbel_pkg::SITE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [cbel_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [cbel_pkg::CLASS_ID_W-1:0] req_class_id,
   input  wire logic [cbel_pkg::SITE_W-1:0]     req_source_site,
   input  wire logic [cbel_pkg::SITE_W-1:0]     req_dest_site,
   input  wire logic [cbel_pkg::INDEX_W-1:0]    req_slot_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [cbel_pkg::STATUS_W-1:0]        rsp_status,
   output logic [cbel_pkg::SITE_W-1:0]          rsp_read_source,
   output logic [cbel_pkg::SITE_W-1:0]          rsp_read_dest,
   output logic [cbel_pkg::COUNT_W-1:0]         rsp_class_count,
   input  wire cbel_pkg::dp_cmd_type            cmd,
   output cbel_pkg::dp_sts_type                 sts
);
   import cbel_pkg::*;

   localparam int unsigned CLASS_BITS = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int unsigned SLOT_BITS  = $clog2(SLOTS_PER_CLASS);
   localparam int unsigned CNT_BITS   = $clog2(SLOTS_PER_CLASS + 1);
   localparam int unsigned STORE_BITS = (SITE_BITS < SITE_W) ? SITE_BITS : SITE_W;
   localparam int unsigned PAIR_W     = 2 * STORE_BITS;
   localparam int unsigned PAIR_AW    = CLASS_BITS + SLOT_BITS;
   localparam int unsigned PAIR_DEPTH = NUM_CLASSES * (1 << SLOT_BITS);

   // memories
   logic [PAIR_W-1:0]   pair_mem [0:PAIR_DEPTH-1];
   logic [CNT_BITS-1:0] cnt_mem  [0:NUM_CLASSES-1];

   logic                pair_we;
   logic [PAIR_AW-1:0]  pair_waddr;
   logic [PAIR_W-1:0]   pair_wdata;
   logic                pair_re;
   logic [PAIR_AW-1:0]  pair_raddr;
   logic [PAIR_W-1:0]   pair_rd_ff;

   logic                  cnt_we;
   logic [CLASS_BITS-1:0] cnt_waddr;
   logic [CNT_BITS-1:0]   cnt_wdata;
   logic [CNT_BITS-1:0]   cnt_rd_ff;

   // latched request
   logic [CMD_W-1:0]      op_ff;
   logic [CLASS_BITS-1:0] cls_ff;
   logic                  range_ff;
   logic [STORE_BITS-1:0] src_ff;
   logic [STORE_BITS-1:0] dst_ff;
   logic [INDEX_W-1:0]    idx_ff;
   logic                  req_in_range;

   // clearing pass and erase scan
   logic [CLASS_BITS-1:0] clr_ptr_ff;
   logic [CLASS_BITS-1:0] clr_ptr_in;
   logic [CNT_BITS-1:0]   scan_ptr_ff;
   logic [CNT_BITS-1:0]   scan_ptr_in;
   logic                  pipe_valid_ff;
   logic                  pipe_valid_in;
   logic [SLOT_BITS-1:0]  pipe_slot_ff;
   logic [SLOT_BITS-1:0]  pipe_slot_in;
   logic                  found_ff;
   logic                  found_in;
   logic                  scan_issue;

   // result held until the output register is free
   logic [STATUS_W-1:0]   res_status_ff;
   logic [STATUS_W-1:0]   res_status_in;
   logic [STORE_BITS-1:0] res_rs_ff;
   logic [STORE_BITS-1:0] res_rs_in;
   logic [STORE_BITS-1:0] res_rd_ff;
   logic [STORE_BITS-1:0] res_rd_in;
   logic [CNT_BITS-1:0]   res_cnt_ff;
   logic [CNT_BITS-1:0]   res_cnt_in;

   // output register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [SITE_W-1:0]     rsp_source_ff;
   logic [SITE_W-1:0]     rsp_dest_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic full;
   logic idx_ok;

   assign req_in_range = (32'(req_class_id) < NUM_CLASSES);
   assign full         = (cnt_rd_ff == CNT_BITS'(SLOTS_PER_CLASS));
   assign idx_ok       = (32'(idx_ff) < 32'(cnt_rd_ff));
   assign scan_issue   = (scan_ptr_ff != cnt_rd_ff);

   assign sts.clr_last  = (clr_ptr_ff == CLASS_BITS'(NUM_CLASSES - 1));
   assign sts.in_range  = range_ff;
   assign sts.op        = op_ff;
   assign sts.idx_ok    = idx_ok;
   assign sts.scan_done = !scan_issue && !pipe_valid_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pair_we       = 1'b0;
      pair_waddr    = {cls_ff, SLOT_BITS'(cnt_rd_ff)};
      pair_wdata    = {src_ff, dst_ff};
      pair_re       = 1'b0;
      pair_raddr    = {cls_ff, SLOT_BITS'(idx_ff)};
      cnt_we        = 1'b0;
      cnt_waddr     = cls_ff;
      cnt_wdata     = cnt_rd_ff;
      clr_ptr_in    = clr_ptr_ff;
      scan_ptr_in   = scan_ptr_ff;
      pipe_valid_in = pipe_valid_ff;
      pipe_slot_in  = pipe_slot_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_rs_in     = res_rs_ff;
      res_rd_in     = res_rd_ff;
      res_cnt_in    = res_cnt_ff;

      if (cmd.clr_wr) begin
         cnt_we     = 1'b1;
         cnt_waddr  = clr_ptr_ff;
         cnt_wdata  = '0;
         clr_ptr_in = clr_ptr_ff + CLASS_BITS'(1);
      end

      if (cmd.decide) begin
         res_status_in = ST_OK;
         res_rs_in     = '0;
         res_rd_in     = '0;
         res_cnt_in    = range_ff ? cnt_rd_ff : '0;
         if (!range_ff) begin
            res_status_in = ST_RANGE;
         end else begin
            case (op_ff)
               OP_INSERT: begin
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     pair_we    = 1'b1;
                     cnt_we     = 1'b1;
                     cnt_wdata  = cnt_rd_ff + CNT_BITS'(1);
                     res_cnt_in = cnt_rd_ff + CNT_BITS'(1);
                  end
               end
               OP_READ: begin
                  if (idx_ok) begin
                     pair_re = 1'b1;
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               OP_ERASE: begin
                  scan_ptr_in   = '0;
                  pipe_valid_in = 1'b0;
                  found_in      = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end

      if (cmd.read_capture) begin
         res_rs_in = pair_rd_ff[PAIR_W-1:STORE_BITS];
         res_rd_in = pair_rd_ff[STORE_BITS-1:0];
      end

      if (cmd.scan_step) begin
         pair_re       = scan_issue;
         pair_raddr    = {cls_ff, SLOT_BITS'(scan_ptr_ff)};
         pipe_valid_in = scan_issue;
         pipe_slot_in  = SLOT_BITS'(scan_ptr_ff);
         if (scan_issue) begin
            scan_ptr_in = scan_ptr_ff + CNT_BITS'(1);
         end
         if (pipe_valid_ff) begin
            if (found_ff) begin
               // close the gap: move this entry down one slot
               pair_we    = 1'b1;
               pair_waddr = {cls_ff, pipe_slot_ff - SLOT_BITS'(1)};
               pair_wdata = pair_rd_ff;
            end else if (pair_rd_ff == {src_ff, dst_ff}) begin
               found_in = 1'b1;
            end
         end
      end

      if (cmd.scan_end) begin
         if (found_ff) begin
            cnt_we     = 1'b1;
            cnt_wdata  = cnt_rd_ff - CNT_BITS'(1);
            res_cnt_in = cnt_rd_ff - CNT_BITS'(1);
         end else begin
            res_status_in = ST_NOT_FOUND;
         end
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (pair_we) begin
         pair_mem[pair_waddr] <= pair_wdata;
      end
      if (pair_re) begin
         pair_rd_ff <= pair_mem[pair_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cmd.load && req_in_range) begin
         cnt_rd_ff <= cnt_mem[CLASS_BITS'(req_class_id)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_cmd;
         cls_ff   <= CLASS_BITS'(req_class_id);
         range_ff <= req_in_range;
         src_ff   <= STORE_BITS'(req_source_site);
         dst_ff   <= STORE_BITS'(req_dest_site);
         idx_ff   <= req_slot_index;
      end
      pipe_slot_ff  <= pipe_slot_in;
      res_status_ff <= res_status_in;
      res_rs_ff     <= res_rs_in;
      res_rd_ff     <= res_rd_in;
      res_cnt_ff    <= res_cnt_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_source_ff <= SITE_W'(res_rs_ff);
         rsp_dest_ff   <= SITE_W'(res_rd_ff);
         rsp_count_ff  <= COUNT_W'(res_cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff    <= '0;
         scan_ptr_ff   <= '0;
         pipe_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_ptr_ff    <= clr_ptr_in;
         scan_ptr_ff   <= scan_ptr_in;
         pipe_valid_ff <= pipe_valid_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_source = rsp_source_ff;
   assign rsp_read_dest   = rsp_dest_ff;
   assign rsp_class_count = rsp_count_ff;

endmodule

`default_nettype wire

// ===== rtl/class_bucketed_event_list.sv =====
// top level of the class bucketed event list: controller, datapath and checks
`default_nettype none

// One compact list of (source, destination) site pairs per event class, with a
// pair count per class; each request beat gives exactly one response beat.
// After reset a clearing pass zeroes the class counts, one class per cycle,
// while req_stall stays high. Requests are handled one at a time. An erase
// walks the whole class list through the pair memory, one read and, once the
// pair is found, one write a cycle, finding the pair and moving later entries
// down in the same pass. A finished response waits in an output register, so
// the next request is taken while the response beat is still stalled.
module class_bucketed_event_list #(
   parameter int unsigned NUM_CLASSES     = cbel_pkg::NUM_CLASSES_DEF,
   parameter int unsigned SLOTS_PER_CLASS = cbel_pkg::SLOTS_PER_CLASS_DEF,
   parameter int unsigned SITE_BITS       = cbel_pkg::SITE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [cbel_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [cbel_pkg::CLASS_ID_W-1:0] req_class_id,
   input  wire logic [cbel_pkg::SITE_W-1:0]     req_source_site,
   input  wire logic [cbel_pkg::SITE_W-1:0]     req_dest_site,
   input  wire logic [cbel_pkg::INDEX_W-1:0]    req_slot_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [cbel_pkg::STATUS_W-1:0]        rsp_status,
   output logic [cbel_pkg::SITE_W-1:0]          rsp_read_source,
   output logic [cbel_pkg::SITE_W-1:0]          rsp_read_dest,
   output logic [cbel_pkg::COUNT_W-1:0]         rsp_class_count
);
   import cbel_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   cbel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cbel_datapath #(
      .NUM_CLASSES     (NUM_CLASSES),
      .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
      .SITE_BITS       (SITE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_class_id    (req_class_id),
      .req_source_site (req_source_site),
      .req_dest_site   (req_dest_site),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_source (rsp_read_source),
      .rsp_read_dest   (rsp_read_dest),
      .rsp_class_count (rsp_class_count),
      .cmd             (cmd),
      .sts             (sts)
   );

   // clearing pass blocks requests straight after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   // one beat at a time: stall rises once a beat is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while one is in flight");

   // a full list reports the full slot count
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         (rsp_class_count == COUNT_W'(SLOTS_PER_CLASS)))
      else $error("full status with short class count");

   // only a good beat carries pair data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_read_source == '0 && rsp_read_dest == '0))
      else $error("error beat carries pair data");

endmodule

`default_nettype wire
